[rtl/core/lmsd_pkg.sv]
// Shared types and constants for the LED matrix scan driver.
// Used by lmsd_frame_store and led_matrix_scan_driver; depends on nothing.
package lmsd_pkg;

   // Request codes on req_type
   localparam logic [1:0] REQ_SET_PIXEL = 2'd0;
   localparam logic [1:0] REQ_FILL      = 2'd1;
   localparam logic [1:0] REQ_SCAN_TICK = 2'd2;

   // Control and status register indexes
   localparam logic [7:0] CSR_PANEL_WIDTH = 8'd0;
   localparam logic [7:0] CSR_SCAN_ROWS   = 8'd1;

   localparam logic [6:0] PANEL_WIDTH_RST = 7'd32;
   localparam logic [4:0] SCAN_ROWS_RST   = 5'd16;

   // Color bits as carried on the ports: bit 0 red, bit 1 green, bit 2 blue
   localparam int COLOR_W = 3;

   typedef struct packed {
      logic               start;
      logic [COLOR_W-1:0] color;
   } fill_cmd_type;

endpackage

[rtl/core/led_matrix_scan_driver.sv]
// Top level of the LED matrix scan driver: command port, control registers, row scan.
// Depends on lmsd_pkg and lmsd_frame_store.
//
// After reset the block clears every entry of its pixel memory with busy high;
// configuration writes are taken meanwhile. A set-pixel transaction writes the
// memory at the accepting edge and busy does not rise. A fill walks the memory
// through its single write port, one entry a cycle, so busy stays high until every
// entry is written. A scan tick reads one column a cycle from the memory read port:
// busy stays high until the last of the effective panel width (8 to 64 columns) is
// read, and the results appear on consecutive cycles, the first once the scan state
// has issued column zero and its read data is registered, each for exactly one cycle
// under rsp_strobe. The receiver cannot stall, so it must take every strobed result.
// csr_ready is always high; write the control registers only while busy is low and
// no results are pending.
module led_matrix_scan_driver
   import lmsd_pkg::*;
#(
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_ROWS     = 16,
   parameter int COLOR_PLANES = 3
) (
   input  logic       clock,
   input  logic       reset,
   // command channel
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_type,
   input  logic [5:0] req_pixel_x,
   input  logic [3:0] req_pixel_y,
   input  logic       req_red_on,
   input  logic       req_green_on,
   input  logic       req_blue_on,
   // result channel
   output logic       rsp_strobe,
   output logic       rsp_data_red,
   output logic       rsp_data_green,
   output logic       rsp_data_blue,
   output logic [3:0] rsp_row_address,
   output logic       rsp_latch_last,
   // control register write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WCW    = COL_W + 1;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type          state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [3:0]         row_ff, row_in;
   logic [3:0]         row_cnt_ff, row_cnt_in;
   logic               rsp_strobe_ff;
   logic               rsp_last_ff;
   logic [3:0]         rsp_row_ff;

   logic [6:0]         panel_width_ff;
   logic [4:0]         scan_rows_ff;

   logic [6:0]         width_round;
   logic [WCW-1:0]     width_eff;
   logic [4:0]         rows_eff;
   logic               accept;
   logic               scan_last;
   logic [3:0]         row_sel;
   logic [3:0]         row_next;
   logic               pixel_in_range;
   logic               px_wr_en;
   logic [ADDR_W-1:0]  px_wr_addr;
   logic [COLOR_W-1:0] req_color;
   logic [ADDR_W-1:0]  rd_addr;
   logic [COLOR_PLANES-1:0] rd_data;
   logic [COLOR_W-1:0] rd_color;
   logic               sweep_busy;
   fill_cmd_type       fill_cmd;

   // Effective geometry: width rounded down to eight and clamped, rows clamped
   assign width_round = {panel_width_ff[6:3], 3'b000};

   always_comb begin
      if (width_round < 7'd8) begin
         width_eff = WCW'(8);
      end else if (int'(width_round) > MAX_WIDTH) begin
         width_eff = WCW'(MAX_WIDTH);
      end else begin
         width_eff = WCW'(width_round);
      end
   end

   always_comb begin
      if (scan_rows_ff == 5'd0) begin
         rows_eff = 5'd1;
      end else if (int'(scan_rows_ff) > MAX_ROWS) begin
         rows_eff = 5'(MAX_ROWS);
      end else begin
         rows_eff = scan_rows_ff;
      end
   end

   assign busy   = (state_ff != S_IDLE) || sweep_busy;
   assign accept = start && !busy;

   assign req_color = {req_blue_on, req_green_on, req_red_on};

   assign pixel_in_range = (int'(req_pixel_x) < int'(width_eff)) &&
                           ({1'b0, req_pixel_y} < rows_eff);
   assign px_wr_en   = accept && (req_type == REQ_SET_PIXEL) && pixel_in_range;
   assign px_wr_addr = ADDR_W'(int'(req_pixel_y) * MAX_WIDTH + int'(req_pixel_x));

   assign fill_cmd.start = accept && (req_type == REQ_FILL);
   assign fill_cmd.color = req_color;

   // Scan a stale counter as row zero when the row count shrank
   assign row_sel  = ({1'b0, row_cnt_ff} >= rows_eff) ? 4'd0 : row_cnt_ff;
   assign row_next = (({1'b0, row_sel} + 5'd1) >= rows_eff) ? 4'd0 : (row_sel + 4'd1);

   assign scan_last = (({1'b0, col_ff} + WCW'(1)) == width_eff);
   assign rd_addr   = ADDR_W'(int'(row_ff) * MAX_WIDTH + int'(col_ff));

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      row_cnt_in = row_cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_type == REQ_SCAN_TICK)) begin
               state_in   = S_SCAN;
               col_in     = '0;
               row_in     = row_sel;
               row_cnt_in = row_next;
            end
         end
         S_SCAN: begin
            col_in = col_ff + COL_W'(1);
            if (scan_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Read data lands in the cycle after the column is issued; carry its tags alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         row_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_cnt_ff    <= row_cnt_in;
         rsp_strobe_ff <= (state_ff == S_SCAN);
      end
      col_ff      <= col_in;
      row_ff      <= row_in;
      rsp_last_ff <= scan_last;
      rsp_row_ff  <= row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff <= PANEL_WIDTH_RST;
         scan_rows_ff   <= SCAN_ROWS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PANEL_WIDTH: panel_width_ff <= csr_wdata[6:0];
            CSR_SCAN_ROWS:   scan_rows_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   lmsd_frame_store #(
      .DEPTH  (DEPTH),
      .PLANES (COLOR_PLANES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .fill_cmd   (fill_cmd),
      .wr_en      (px_wr_en),
      .wr_addr    (px_wr_addr),
      .wr_data    (req_color[COLOR_PLANES-1:0]),
      .rd_en      (state_ff == S_SCAN),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .sweep_busy (sweep_busy)
   );

   // Planes that are not stored read as zero
   assign rd_color = COLOR_W'(rd_data);

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_data_red    = rd_color[0];
   assign rsp_data_green  = rd_color[1];
   assign rsp_data_blue   = rd_color[2];
   assign rsp_row_address = rsp_row_ff;
   assign rsp_latch_last  = rsp_last_ff;

   a_strobe_follows_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_SCAN))
      else $error("result strobe without a scanned column");

   a_latch_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_latch_last) |-> (state_ff == S_IDLE))
      else $error("scan still running after latch column");

   a_scan_excludes_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !sweep_busy)
      else $error("scan overlaps fill sweep");

   a_scan_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> ({1'b0, row_ff} < rows_eff))
      else $error("scanned row beyond row count");

endmodule

[rtl/core/lmsd_frame_store.sv]
// Pixel memory of the LED matrix scan driver with its fill sweeper.
// Depends on lmsd_pkg; instantiated by led_matrix_scan_driver.
module lmsd_frame_store
   import lmsd_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int PLANES = 3,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  fill_cmd_type      fill_cmd,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [PLANES-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [PLANES-1:0] rd_data,
   output logic              sweep_busy
);

   typedef enum logic {
      S_READY,
      S_SWEEP
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   sweep_addr_ff, sweep_addr_in;
   logic [PLANES-1:0]   sweep_color_ff, sweep_color_in;
   logic [PLANES-1:0]   mem [DEPTH];
   logic [PLANES-1:0]   rd_data_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [PLANES-1:0]   mem_wdata;
   logic                sweep_last;

   assign sweep_last = (sweep_addr_ff == ADDR_W'(DEPTH - 1));

   always_comb begin
      state_in       = state_ff;
      sweep_addr_in  = sweep_addr_ff;
      sweep_color_in = sweep_color_ff;
      case (state_ff)
         S_READY: begin
            if (fill_cmd.start) begin
               state_in       = S_SWEEP;
               sweep_addr_in  = '0;
               sweep_color_in = fill_cmd.color[PLANES-1:0];
            end
         end
         S_SWEEP: begin
            sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            if (sweep_last) begin
               state_in = S_READY;
            end
         end
         default: state_in = S_READY;
      endcase
   end

   // Reset starts a clearing pass with black
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_SWEEP;
         sweep_addr_ff  <= '0;
         sweep_color_ff <= '0;
      end else begin
         state_ff       <= state_in;
         sweep_addr_ff  <= sweep_addr_in;
         sweep_color_ff <= sweep_color_in;
      end
   end

   assign mem_we    = (state_ff == S_SWEEP) || wr_en;
   assign mem_waddr = (state_ff == S_SWEEP) ? sweep_addr_ff : wr_addr;
   assign mem_wdata = (state_ff == S_SWEEP) ? sweep_color_ff : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign sweep_busy = (state_ff == S_SWEEP);

   a_no_write_during_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> !wr_en)
      else $error("pixel write collided with fill sweep");

   a_no_read_during_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> !rd_en)
      else $error("scan read during fill sweep");

   a_fill_only_when_ready: assert property (@(posedge clock) disable iff (reset)
      fill_cmd.start |-> (state_ff == S_READY))
      else $error("fill started while sweep in progress");

endmodule

[sim/led_matrix_scan_driver_tb.sv]
// Self-checking testbench for led_matrix_scan_driver: frame store writes, fills and row scans.
// Depends on lmsd_pkg and the RTL of the block; predicts every shift beat and compares
// it with the result port, field by field, under varying panel settings and pacing.
module led_matrix_scan_driver_tb;
   import lmsd_pkg::*;

   localparam int MAX_W          = 64;
   localparam int MAX_R          = 16;
   localparam int STORE_DEPTH    = MAX_W * MAX_R;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 6000;

   localparam logic [1:0] REQ_UNDEFINED    = 2'd3;
   localparam logic [7:0] CSR_UNMAPPED_TOP = 8'hFF;

   typedef enum logic [1:0] {STEP_CMD, STEP_CSR, STEP_DRAIN, STEP_PACE} step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [1:0]    rtype;
      logic [5:0]    x;
      logic [3:0]    y;
      logic [2:0]    color;
      logic [7:0]    index;
      logic [7:0]    data;
      int            pct;
   } sched_entry_type;

   typedef struct packed {
      logic       red;
      logic       green;
      logic       blue;
      logic [3:0] row;
      logic       last;
   } shift_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_type = REQ_SET_PIXEL;
   logic [5:0] req_pixel_x = '0;
   logic [3:0] req_pixel_y = '0;
   logic       req_red_on = 1'b0;
   logic       req_green_on = 1'b0;
   logic       req_blue_on = 1'b0;
   logic       rsp_strobe;
   logic       rsp_data_red;
   logic       rsp_data_green;
   logic       rsp_data_blue;
   logic [3:0] rsp_row_address;
   logic       rsp_latch_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   sched_entry_type cmd_backlog[$];
   shift_beat_type  shift_beats_due[$];

   // Predicted copy of the block state
   logic [2:0] frame_bits [0:STORE_DEPTH-1];
   logic [3:0] scan_row;
   logic [6:0] width_reg;
   logic [4:0] rows_reg;

   int idle_pct = 0;
   int settle_cnt = 0;
   int quiet_cycles = 0;
   int errors = 0;
   int cmds_done = 0;
   int ticks_done = 0;
   int csr_done = 0;
   int beats_seen = 0;

   led_matrix_scan_driver dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_red_on      (req_red_on),
      .req_green_on    (req_green_on),
      .req_blue_on     (req_blue_on),
      .rsp_strobe      (rsp_strobe),
      .rsp_data_red    (rsp_data_red),
      .rsp_data_green  (rsp_data_green),
      .rsp_data_blue   (rsp_data_blue),
      .rsp_row_address (rsp_row_address),
      .rsp_latch_last  (rsp_latch_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int active_columns(input logic [6:0] raw);
      int w;
      w = int'(raw) & ~7;
      if (w < 8) w = 8;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int active_rows(input logic [4:0] raw);
      int r;
      r = int'(raw);
      if (r < 1) r = 1;
      if (r > MAX_R) r = MAX_R;
      return r;
   endfunction

   // Update the predicted store; a scan tick queues one beat per column
   task automatic apply_command(input logic [1:0] rt, input logic [5:0] x,
                                input logic [3:0] y, input logic [2:0] color);
      int cols;
      int rows;
      int row;
      int nxt;
      int i;
      int col;
      shift_beat_type beat;
      cols = active_columns(width_reg);
      rows = active_rows(rows_reg);
      case (rt)
         REQ_SET_PIXEL: begin
            if (int'(x) < cols && int'(y) < rows) frame_bits[int'(y) * MAX_W + int'(x)] = color;
         end
         REQ_FILL: begin
            for (i = 0; i < STORE_DEPTH; i++) frame_bits[i] = color;
         end
         REQ_SCAN_TICK: begin
            row = (int'(scan_row) >= rows) ? 0 : int'(scan_row);
            for (col = 0; col < cols; col++) begin
               beat.red   = frame_bits[row * MAX_W + col][0];
               beat.green = frame_bits[row * MAX_W + col][1];
               beat.blue  = frame_bits[row * MAX_W + col][2];
               beat.row   = row[3:0];
               beat.last  = (col == cols - 1);
               shift_beats_due.push_back(beat);
            end
            nxt = row + 1;
            if (nxt >= rows) nxt = 0;
            scan_row = nxt[3:0];
            ticks_done++;
         end
         default: ;
      endcase
   endtask

   // Four-state compare so an unknown output never passes for a zero
   task automatic check_field(input string what, input logic [3:0] want,
                              input logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
         errors++;
      end
   endtask

   task automatic add_cmd(input logic [1:0] rt, input logic [5:0] x, input logic [3:0] y,
                          input logic [2:0] color);
      sched_entry_type e;
      e = '{kind: STEP_CMD, rtype: rt, x: x, y: y, color: color, index: '0, data: '0, pct: 0};
      cmd_backlog.push_back(e);
   endtask

   task automatic add_csr(input logic [7:0] idx, input logic [7:0] data);
      sched_entry_type e;
      e = '{kind: STEP_CSR, rtype: REQ_SET_PIXEL, x: '0, y: '0, color: '0, index: idx,
            data: data, pct: 0};
      cmd_backlog.push_back(e);
   endtask

   task automatic add_marker(input step_kind_type kind, input int pct);
      sched_entry_type e;
      e = '{kind: kind, rtype: REQ_SET_PIXEL, x: '0, y: '0, color: '0, index: '0, data: '0,
            pct: pct};
      cmd_backlog.push_back(e);
   endtask

   // Random transactions for one phase; most set-pixel transactions land on the active panel
   task automatic add_random(input int count, input int cols, input int rows);
      int k;
      int sel;
      for (k = 0; k < count; k++) begin
         sel = int'($urandom_range(99));
         if (sel < 40)
            add_cmd(REQ_SET_PIXEL, 6'($urandom_range(cols - 1)),
                    4'($urandom_range(rows - 1)), 3'($urandom_range(7)));
         else if (sel < 48)
            add_cmd(REQ_SET_PIXEL, 6'($urandom_range(63)), 4'($urandom_range(15)),
                    3'($urandom_range(7)));
         else if (sel < 90)
            add_cmd(REQ_SCAN_TICK, 6'($urandom_range(63)), 4'($urandom_range(15)),
                    3'($urandom_range(7)));
         else if (sel < 94)
            add_cmd(REQ_FILL, 6'($urandom_range(63)), 4'($urandom_range(15)),
                    3'($urandom_range(7)));
         else
            add_cmd(REQ_UNDEFINED, 6'($urandom_range(63)), 4'($urandom_range(15)),
                    3'($urandom_range(7)));
      end
   endtask

   // Driver: the predictor runs on each accepted transaction
   always @(posedge clock) begin : driver
      sched_entry_type head;
      logic quiet;
      logic start_n;
      logic csr_n;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) frame_bits[i] = '0;
         scan_row = '0;
         width_reg = PANEL_WIDTH_RST;
         rows_reg = SCAN_ROWS_RST;
         settle_cnt = 0;
         start <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_command(req_type, req_pixel_x, req_pixel_y,
                          {req_blue_on, req_green_on, req_red_on});
            cmds_done++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PANEL_WIDTH) width_reg = csr_wdata[6:0];
            else if (csr_index == CSR_SCAN_ROWS) rows_reg = csr_wdata[4:0];
            csr_done++;
         end
         quiet = shift_beats_due.size() == 0 && !rsp_strobe && !busy && !start && !csr_valid;
         settle_cnt = quiet ? settle_cnt + 1 : 0;
         if (start && busy) begin
            // hold the transaction until the block takes it
         end else if (csr_valid && !csr_ready) begin
            // hold the register write
         end else begin
            start_n = 1'b0;
            csr_n = 1'b0;
            if (cmd_backlog.size() != 0) begin
               head = cmd_backlog[0];
               case (head.kind)
                  STEP_PACE: begin
                     idle_pct = head.pct;
                     void'(cmd_backlog.pop_front());
                  end
                  STEP_DRAIN: begin
                     if (settle_cnt >= SETTLE_CYCLES) void'(cmd_backlog.pop_front());
                  end
                  STEP_CSR: begin
                     if (settle_cnt >= SETTLE_CYCLES) begin
                        csr_n = 1'b1;
                        csr_index <= head.index;
                        csr_wdata <= head.data;
                        void'(cmd_backlog.pop_front());
                     end
                  end
                  default: begin
                     if (int'($urandom_range(99)) >= idle_pct) begin
                        start_n = 1'b1;
                        req_type <= head.rtype;
                        req_pixel_x <= head.x;
                        req_pixel_y <= head.y;
                        req_red_on <= head.color[0];
                        req_green_on <= head.color[1];
                        req_blue_on <= head.color[2];
                        void'(cmd_backlog.pop_front());
                     end
                  end
               endcase
            end
            start <= start_n;
            csr_valid <= csr_n;
         end
      end
   end

   always @(posedge clock) begin : monitor
      shift_beat_type want;
      if (rsp_strobe) begin
         if (shift_beats_due.size() == 0) begin
            $display("%0t: shift beat with none expected: expected nothing, got row %0d",
                     $time, rsp_row_address);
            errors++;
         end else begin
            want = shift_beats_due.pop_front();
            check_field("data_red", 4'(want.red), 4'(rsp_data_red));
            check_field("data_green", 4'(want.green), 4'(rsp_data_green));
            check_field("data_blue", 4'(want.blue), 4'(rsp_data_blue));
            check_field("row_address", want.row, rsp_row_address);
            check_field("latch_last", 4'(want.last), 4'(rsp_latch_last));
            beats_seen++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("** led_matrix_scan_driver: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [7:0] wdat;
      logic [7:0] rdat;
      // Directed part, first under the reset settings: 32 columns, 16 rows
      add_marker(STEP_PACE, 0);
      add_cmd(REQ_SCAN_TICK, 6'd0, 4'd0, 3'b000);
      add_cmd(REQ_SET_PIXEL, 6'd0, 4'd1, 3'b111);
      add_cmd(REQ_SET_PIXEL, 6'd31, 4'd1, 3'b101);
      add_cmd(REQ_SET_PIXEL, 6'd32, 4'd1, 3'b111);
      add_cmd(REQ_SET_PIXEL, 6'd63, 4'd15, 3'b111);
      add_cmd(REQ_SET_PIXEL, 6'd5, 4'd15, 3'b010);
      add_cmd(REQ_SCAN_TICK, 6'd63, 4'd15, 3'b111);
      add_cmd(REQ_UNDEFINED, 6'd63, 4'd15, 3'b111);
      add_cmd(REQ_FILL, 6'd0, 4'd0, 3'b111);
      add_cmd(REQ_SCAN_TICK, 6'd0, 4'd0, 3'b000);
      add_cmd(REQ_FILL, 6'd0, 4'd0, 3'b000);
      add_cmd(REQ_SCAN_TICK, 6'd0, 4'd0, 3'b000);
      // Shrink the row count below the counter so the next tick falls back to row zero
      add_csr(CSR_PANEL_WIDTH, 8'd64);
      add_csr(CSR_SCAN_ROWS, 8'd4);
      add_cmd(REQ_SET_PIXEL, 6'd63, 4'd3, 3'b110);
      add_cmd(REQ_SET_PIXEL, 6'd10, 4'd4, 3'b111);
      add_cmd(REQ_SET_PIXEL, 6'd63, 4'd0, 3'b001);
      repeat (5) add_cmd(REQ_SCAN_TICK, 6'd0, 4'd0, 3'b000);
      add_csr(CSR_PANEL_WIDTH, 8'd8);
      add_csr(CSR_SCAN_ROWS, 8'd1);
      add_cmd(REQ_SET_PIXEL, 6'd7, 4'd0, 3'b111);
      add_cmd(REQ_SET_PIXEL, 6'd8, 4'd0, 3'b111);
      add_cmd(REQ_SCAN_TICK, 6'd0, 4'd0, 3'b000);
      add_cmd(REQ_SCAN_TICK, 6'd0, 4'd0, 3'b000);

      // Random phases; register values include the extremes and out-of-range codes
      add_csr(CSR_PANEL_WIDTH, 8'd64);
      add_csr(CSR_SCAN_ROWS, 8'd16);
      add_random(35, 64, 16);

      add_marker(STEP_PACE, 76);
      add_csr(CSR_PANEL_WIDTH, 8'd8);
      add_csr(CSR_SCAN_ROWS, 8'd1);
      add_random(35, 8, 1);

      add_marker(STEP_PACE, 17);
      add_csr(CSR_PANEL_WIDTH, 8'hFF);
      add_csr(CSR_SCAN_ROWS, 8'hFF);
      add_csr(CSR_UNMAPPED_TOP, 8'h00);
      add_random(17, 64, 16);
      add_marker(STEP_DRAIN, 0);
      add_random(18, 64, 16);

      add_marker(STEP_PACE, 0);
      add_csr(CSR_PANEL_WIDTH, 8'd0);
      add_csr(CSR_SCAN_ROWS, 8'd0);
      add_random(35, 8, 1);

      add_marker(STEP_PACE, 76);
      wdat = 8'($urandom_range(255));
      rdat = 8'($urandom_range(255));
      add_csr(CSR_PANEL_WIDTH, wdat);
      add_csr(CSR_SCAN_ROWS, rdat);
      add_csr(8'($urandom_range(255, 2)), 8'($urandom_range(255)));
      add_random(17, active_columns(wdat[6:0]), active_rows(rdat[4:0]));
      add_marker(STEP_DRAIN, 0);
      add_random(18, active_columns(wdat[6:0]), active_rows(rdat[4:0]));

      add_marker(STEP_PACE, 17);
      add_csr(CSR_PANEL_WIDTH, 8'd13);
      add_csr(CSR_SCAN_ROWS, 8'd5);
      add_random(11, 8, 5);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || shift_beats_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shift_beats_due.size() != 0) begin
         $display("%0t: shift beats never seen: expected %0d more, got 0", $time,
                  shift_beats_due.size());
         errors++;
      end
      $display("Covered %0d commands (%0d scan ticks) over %0d register writes;",
               cmds_done, ticks_done, csr_done);
      $display("compared %0d shift beats, %0d mismatches.", beats_seen, errors);
      if (errors == 0) begin
         $display("** led_matrix_scan_driver: PASSED **");
      end else begin
         $display("** led_matrix_scan_driver: FAILED **");
      end
      $finish;
   end

endmodule

[led_matrix_scan_driver.f]
rtl/core/lmsd_pkg.sv
rtl/core/lmsd_frame_store.sv
rtl/core/led_matrix_scan_driver.sv
sim/led_matrix_scan_driver_tb.sv
